// ===== rtl/rzof_pkg.sv =====
// Shared widths, codes and state encoding for the residual z-score outlier flagger.
package rzof_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int IN_W         = 32;
  localparam int RES_W        = 33;
  localparam int MEAN_W       = RES_W + 1;
  localparam int DEV_W        = RES_W + 2;
  localparam int MAG_W        = 34;
  localparam int HALF_W       = MAG_W / 2;
  localparam int FRAC_W       = 16;
  localparam int Z_W          = 24;
  localparam int THR_W        = 24;
  localparam int OBS_W        = 7;
  localparam int MIN_ITEMS    = 3;

  localparam logic [THR_W-1:0] THRESHOLD_RST = 24'd163840;
  localparam logic [Z_W-1:0]   ZMAG_POS_MAX  = 24'h7FFFFF;
  localparam logic [Z_W-1:0]   ZMAG_NEG_MAX  = 24'h800000;

  typedef enum logic [1:0] {
    STATUS_OK  = 2'd0,
    STATUS_FEW = 2'd1,
    STATUS_OVF = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_MEAN,
    ST_SSD,
    ST_VAR,
    ST_SQRT,
    ST_RD,
    ST_DEV,
    ST_ZDIV,
    ST_EMIT
  } state_e;

endpackage

// ===== rtl/residual_zscore_outlier_flagger_top.sv =====
// Top level of the residual z-score outlier flagger.
//
//  channel | handshake                   | words
//  --------+-----------------------------+------------------------------------------------
//  in      | in_valid_i / in_stall_o     | actual_value_i, predicted_value_i, last_of_set_i
//  out     | out_valid_o / out_stall_i   | obs_index_o, residual_o, std_residual_o,
//          |                             | outlier_flag_o, status_o, last_result_o
//  cfg     | cfg_valid_i / cfg_ready_o   | cfg_data_i (outlier threshold)
//
// Each stored pair is one write into the residual memory and one add. On the last pair of
// a valid set the block runs one divider pass for the mean, a multiply-accumulate pass for
// the squared-deviation sum, one divider pass for the variance, one square-root step per
// root bit and one divider pass per result unless the standard deviation is zero. Input
// is stalled from the last pair until the final result is loaded, and while a result waits
// in the output register. Reset needs no clearing pass.
module residual_zscore_outlier_flagger_top import rzof_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [IN_W-1:0]  actual_value_i,
  input  logic signed [IN_W-1:0]  predicted_value_i,
  input  logic                    last_of_set_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [OBS_W-1:0]        obs_index_o,
  output logic signed [RES_W-1:0] residual_o,
  output logic signed [Z_W-1:0]   std_residual_o,
  output logic                    outlier_flag_o,
  output logic [1:0]              status_o,
  output logic                    last_result_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [THR_W-1:0]        cfg_data_i
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = RES_W + AW;
  localparam int SSD_W = 2 * MAG_W + AW;
  localparam int SD_W  = (SSD_W + 1) / 2;
  localparam int SQ_CW = $clog2(SD_W + 1);
  localparam int ZD_W  = MAG_W + FRAC_W;

  logic signed [RES_W-1:0] mem [CAPACITY];

  state_e                  state_q, state_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic                    ovf_q, ovf_d;
  logic [THR_W-1:0]        thr_q, thr_d;
  logic [AW-1:0]           idx_q, idx_d;
  logic [2:0]              ph_q, ph_d;
  logic signed [MEAN_W-1:0] mean_q, mean_d;
  logic [MAG_W-1:0]        mag_q, mag_d;
  logic                    neg_q, neg_d;
  logic [MAG_W-1:0]        prod_q, prod_d;
  logic [SSD_W-1:0]        acc_q, acc_d;
  logic [2*SD_W-1:0]       var_q, var_d;
  logic [SD_W+1:0]         rem_q, rem_d;
  logic [SD_W-1:0]         root_q, root_d;
  logic [SQ_CW-1:0]        sqc_q, sqc_d;
  logic [SD_W-1:0]         sd_q, sd_d;
  logic signed [Z_W-1:0]   z_q, z_d;
  logic                    flag_q, flag_d;
  logic signed [RES_W-1:0] rd_q;

  logic                    out_valid_q, out_valid_d;
  logic [OBS_W-1:0]        obs_q, obs_d;
  logic signed [RES_W-1:0] ores_q, ores_d;
  logic signed [Z_W-1:0]   oz_q, oz_d;
  logic                    oflag_q, oflag_d;
  status_e                 status_q, status_d;
  logic                    olast_q, olast_d;

  logic                    accept, out_free, mem_we, rd_en, is_last_idx;
  logic signed [RES_W-1:0] in_res;
  logic [SUM_W-1:0]        sum_abs;
  logic signed [DEV_W-1:0] dev, dev_abs;
  logic [HALF_W-1:0]       mul_a, mul_b;
  logic [MAG_W-1:0]        mul_p;
  logic [SD_W+3:0]         sq_sh, sq_trial;
  logic [Z_W-1:0]          zmag;
  logic [AW:0]             idx_p1;

  logic                    div_start, div_done;
  logic [SSD_W-1:0]        div_dvd, div_quot;
  logic [SD_W-1:0]         div_dvs;

  rzof_div #(.DVD_W(SSD_W), .DVS_W(SD_W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign in_stall_o  = (state_q != ST_LOAD) || out_valid_q;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign in_res      = {actual_value_i[IN_W-1], actual_value_i}
                     - {predicted_value_i[IN_W-1], predicted_value_i};
  assign rd_en       = (state_q == ST_RD) || (state_q == ST_SSD && ph_q == 3'd0);
  assign is_last_idx = {1'b0, idx_q} == (cnt_q - 1'b1);
  assign idx_p1      = {1'b0, idx_q} + 1'b1;

  // one shared 17x17 multiplier: low*low, low*high, high*high
  assign mul_a = (ph_q == 3'd4) ? mag_q[MAG_W-1:HALF_W] : mag_q[HALF_W-1:0];
  assign mul_b = (ph_q == 3'd2) ? mag_q[HALF_W-1:0] : mag_q[MAG_W-1:HALF_W];
  assign mul_p = mul_a * mul_b;

  assign dev     = {{2{rd_q[RES_W-1]}}, rd_q} - {mean_q[MEAN_W-1], mean_q};
  assign dev_abs = dev[DEV_W-1] ? -dev : dev;

  assign sq_sh    = {rem_q, var_q[2*SD_W-1 -: 2]};
  assign sq_trial = {2'b00, root_q, 2'b01};

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    ovf_d       = ovf_q;
    thr_d       = cfg_valid_i ? cfg_data_i : thr_q;
    idx_d       = idx_q;
    ph_d        = ph_q;
    mean_d      = mean_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    prod_d      = prod_q;
    acc_d       = acc_q;
    var_d       = var_q;
    rem_d       = rem_q;
    root_d      = root_q;
    sqc_d       = sqc_q;
    sd_d        = sd_q;
    z_d         = z_q;
    flag_d      = flag_q;
    out_valid_d = out_valid_q && out_stall_i;
    obs_d       = obs_q;
    ores_d      = ores_q;
    oz_d        = oz_q;
    oflag_d     = oflag_q;
    status_d    = status_q;
    olast_d     = olast_q;
    mem_we      = 1'b0;
    div_start   = 1'b0;
    div_dvd     = '0;
    div_dvs     = '0;
    sum_abs     = '0;
    zmag        = '0;

    case (state_q)
      ST_LOAD: begin
        if (accept) begin
          if (cnt_q < CNT_W'(CAPACITY)) begin
            mem_we = 1'b1;
            sum_d  = sum_q + {{AW{in_res[RES_W-1]}}, in_res};
            cnt_d  = cnt_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (last_of_set_i) begin
            if (ovf_d || cnt_d < CNT_W'(MIN_ITEMS)) begin
              out_valid_d = 1'b1;
              obs_d       = '0;
              ores_d      = '0;
              oz_d        = '0;
              oflag_d     = 1'b0;
              status_d    = ovf_d ? STATUS_OVF : STATUS_FEW;
              olast_d     = 1'b1;
              cnt_d       = '0;
              sum_d       = '0;
              ovf_d       = 1'b0;
            end else begin
              sum_abs   = sum_d[SUM_W-1] ? -sum_d : sum_d;
              div_start = 1'b1;
              div_dvd   = {{(SSD_W-SUM_W){1'b0}}, sum_abs};
              div_dvs   = SD_W'(cnt_d);
              state_d   = ST_MEAN;
            end
          end
        end
      end
      ST_MEAN: begin
        if (div_done) begin
          mean_d  = sum_q[SUM_W-1] ? -signed'(div_quot[MEAN_W-1:0])
                                   : signed'(div_quot[MEAN_W-1:0]);
          idx_d   = '0;
          ph_d    = 3'd0;
          acc_d   = '0;
          state_d = ST_SSD;
        end
      end
      ST_SSD: begin
        case (ph_q)
          3'd0: ph_d = 3'd1;
          3'd1: begin
            mag_d = dev_abs[MAG_W-1:0];
            ph_d  = 3'd2;
          end
          3'd2: begin
            prod_d = mul_p;
            ph_d   = 3'd3;
          end
          3'd3: begin
            acc_d  = acc_q + SSD_W'(prod_q);
            prod_d = mul_p;
            ph_d   = 3'd4;
          end
          3'd4: begin
            acc_d  = acc_q + (SSD_W'(prod_q) << (HALF_W + 1));
            prod_d = mul_p;
            ph_d   = 3'd5;
          end
          3'd5: begin
            acc_d = acc_q + (SSD_W'(prod_q) << MAG_W);
            ph_d  = 3'd0;
            if (is_last_idx) begin
              div_start = 1'b1;
              div_dvd   = acc_d;
              div_dvs   = SD_W'(cnt_q - 1'b1);
              state_d   = ST_VAR;
            end else begin
              idx_d = idx_q + 1'b1;
            end
          end
          default: ph_d = 3'd0;
        endcase
      end
      ST_VAR: begin
        if (div_done) begin
          var_d   = (2*SD_W)'(div_quot);
          rem_d   = '0;
          root_d  = '0;
          sqc_d   = '0;
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        // take two radicand bits a step, settle one root bit
        var_d = var_q << 2;
        if (sq_sh >= sq_trial) begin
          rem_d  = (SD_W+2)'(sq_sh - sq_trial);
          root_d = {root_q[SD_W-2:0], 1'b1};
        end else begin
          rem_d  = sq_sh[SD_W+1:0];
          root_d = {root_q[SD_W-2:0], 1'b0};
        end
        sqc_d = sqc_q + 1'b1;
        if (sqc_q == SQ_CW'(SD_W - 1)) begin
          sd_d    = root_d;
          idx_d   = '0;
          state_d = ST_RD;
        end
      end
      ST_RD: state_d = ST_DEV;
      ST_DEV: begin
        mag_d = dev_abs[MAG_W-1:0];
        neg_d = dev[DEV_W-1];
        if (sd_q == '0) begin
          z_d     = '0;
          flag_d  = 1'b0;
          state_d = ST_EMIT;
        end else begin
          div_start = 1'b1;
          div_dvd   = SSD_W'({dev_abs[MAG_W-1:0], {FRAC_W{1'b0}}});
          div_dvs   = sd_q;
          state_d   = ST_ZDIV;
        end
      end
      ST_ZDIV: begin
        if (div_done) begin
          if (neg_q) begin
            zmag = (div_quot >= SSD_W'(ZMAG_NEG_MAX)) ? ZMAG_NEG_MAX : div_quot[Z_W-1:0];
            z_d  = -signed'(zmag);
          end else begin
            zmag = (div_quot > SSD_W'(ZMAG_POS_MAX)) ? ZMAG_POS_MAX : div_quot[Z_W-1:0];
            z_d  = signed'(zmag);
          end
          flag_d  = zmag > thr_q;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          obs_d       = OBS_W'(idx_p1);
          ores_d      = rd_q;
          oz_d        = z_q;
          oflag_d     = flag_q;
          status_d    = STATUS_OK;
          olast_d     = is_last_idx;
          if (is_last_idx) begin
            cnt_d   = '0;
            sum_d   = '0;
            ovf_d   = 1'b0;
            state_d = ST_LOAD;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_RD;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      cnt_q       <= '0;
      sum_q       <= '0;
      ovf_q       <= 1'b0;
      thr_q       <= THRESHOLD_RST;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      ph_q        <= 3'd0;
      sqc_q       <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      ovf_q       <= ovf_d;
      thr_q       <= thr_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      ph_q        <= ph_d;
      sqc_q       <= sqc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mean_q   <= mean_d;
    mag_q    <= mag_d;
    neg_q    <= neg_d;
    prod_q   <= prod_d;
    acc_q    <= acc_d;
    var_q    <= var_d;
    rem_q    <= rem_d;
    root_q   <= root_d;
    sd_q     <= sd_d;
    z_q      <= z_d;
    flag_q   <= flag_d;
    obs_q    <= obs_d;
    ores_q   <= ores_d;
    oz_q     <= oz_d;
    oflag_q  <= oflag_d;
    status_q <= status_d;
    olast_q  <= olast_d;
  end

  // residual memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[cnt_q[AW-1:0]] <= in_res;
    end
    if (rd_en) begin
      rd_q <= mem[idx_q];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign obs_index_o    = obs_q;
  assign residual_o     = ores_q;
  assign std_residual_o = oz_q;
  assign outlier_flag_o = oflag_q;
  assign status_o       = status_q;
  assign last_result_o  = olast_q;

endmodule

// ===== rtl/rzof_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module rzof_div #(
  parameter int DVD_W = 74,
  parameter int DVS_W = 37
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quot_o
);

  localparam int CW = $clog2(DVD_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  always_comb begin
    trial  = {rem_q, quo_q[DVD_W-1]};
    diff   = trial - {1'b0, dvs_q};
    ge     = trial >= {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_d = {quo_q[DVD_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== rtl/rzof_chk.sv =====
// Port-level checks for the residual z-score outlier flagger, bound to the top level.
module rzof_chk import rzof_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic [OBS_W-1:0]        obs_index_o,
  input logic signed [RES_W-1:0] residual_o,
  input logic signed [Z_W-1:0]   std_residual_o,
  input logic                    outlier_flag_o,
  input logic [1:0]              status_o,
  input logic                    last_result_o
);

  // a stalled result stays valid with its index, residual and z-score held
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(residual_o)
      && $stable(obs_index_o) && $stable(std_residual_o))
    else $error("stalled result word changed");

  // error word carries zero payload and closes the set
  a_err_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STATUS_OK |-> obs_index_o == '0 && last_result_o
      && std_residual_o == '0 && !outlier_flag_o && residual_o == '0)
    else $error("malformed error word");

  // good results are numbered from one
  a_ok_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_OK |-> obs_index_o != '0)
    else $error("good result with index zero");

  // input holds off while a result waits
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while a result waits");

endmodule

bind residual_zscore_outlier_flagger_top rzof_chk u_rzof_chk (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for the residual z-score outlier flagger top level.
`timescale 1ns / 100ps

module testbench import rzof_pkg::*; ();

  localparam int CAP = 64;
  localparam int MAX_MISMATCH_SHOWN = 10;

  typedef struct packed {
    logic [OBS_W-1:0]        idx;
    logic signed [RES_W-1:0] res;
    logic signed [Z_W-1:0]   z;
    logic                    flag;
    logic [1:0]              status;
    logic                    last;
  } flag_word_t;

  typedef struct {
    logic signed [IN_W-1:0] act;
    logic signed [IN_W-1:0] pred;
    logic                   last;
    bit                     typed;
    status_e                want_status;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [IN_W-1:0] actual_value_i = '0;
  logic signed [IN_W-1:0] predicted_value_i = '0;
  logic last_of_set_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [OBS_W-1:0] obs_index_o;
  logic signed [RES_W-1:0] residual_o;
  logic signed [Z_W-1:0] std_residual_o;
  logic outlier_flag_o;
  logic [1:0] status_o;
  logic last_result_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [THR_W-1:0] cfg_data_i = '0;

  residual_zscore_outlier_flagger_top #(.CAPACITY(CAP)) dut (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [THR_W-1:0]        thr_q = THRESHOLD_RST;
  logic signed [RES_W-1:0] res_mem [CAP];
  int                      n_stored = 0;
  logic signed [63:0]      res_total = 0;
  bit                      overflowed = 0;

  flag_word_t expected_words[$];
  int mismatches = 0;
  bit no_idle = 0;
  bit hold_rx = 0;
  int idle_pct = 38;

  function automatic logic [63:0] isqrt128(input logic [127:0] v);
    logic [63:0] root;
    logic [63:0] cand;
    root = 0;
    for (int b = 41; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if (128'(cand) * 128'(cand) <= v) root = cand;
    end
    return root;
  endfunction

  // Store one pair; on the end of a set queue the words it must produce.
  function automatic void predict_pair(input logic signed [IN_W-1:0] a,
                                       input logic signed [IN_W-1:0] p, input logic lst);
    logic signed [RES_W-1:0] r;
    logic signed [63:0] mean, d, z;
    logic [127:0] ssd;
    logic [63:0] sd, m;
    flag_word_t w;
    r = RES_W'(a) - RES_W'(p);
    if (n_stored < CAP) begin
      res_mem[n_stored] = r;
      res_total += 64'(r);
      n_stored++;
    end else overflowed = 1;
    if (!lst) return;
    if (overflowed || n_stored < MIN_ITEMS) begin
      w = '0;
      w.status = overflowed ? STATUS_OVF : STATUS_FEW;
      w.last = 1;
      expected_words.insert(expected_words.size(), w);
    end else begin
      mean = res_total / n_stored;
      ssd = 0;
      for (int i = 0; i < n_stored; i++) begin
        d = 64'(res_mem[i]) - mean;
        m = d < 0 ? -d : d;
        ssd += 128'(m) * 128'(m);
      end
      sd = isqrt128(ssd / (n_stored - 1));
      for (int i = 0; i < n_stored; i++) begin
        d = 64'(res_mem[i]) - mean;
        z = 0;
        w = '0;
        if (sd != 0) begin
          z = (d * 64'sd65536) / $signed(sd);
          if (z > 64'sd8388607) z = 64'sd8388607;
          if (z < -64'sd8388608) z = -64'sd8388608;
          w.flag = ((z < 0) ? -z : z) > 64'(thr_q);
        end
        w.idx = OBS_W'(i + 1);
        w.res = res_mem[i];
        w.z = Z_W'(z);
        w.status = STATUS_OK;
        w.last = (i + 1 == n_stored);
        expected_words.insert(expected_words.size(), w);
      end
    end
    n_stored = 0;
    res_total = 0;
    overflowed = 0;
  endfunction

  // compare every accepted output word
  always @(posedge clk_i) begin
    flag_word_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_MISMATCH_SHOWN)
          $display("unexpected word idx=%0d res=%0d", obs_index_o, residual_o);
      end else begin
        e = expected_words.pop_front();
        if (e.idx !== obs_index_o || e.res !== residual_o || e.z !== std_residual_o ||
            e.flag !== outlier_flag_o || e.status !== status_o || e.last !== last_result_o)
        begin
          mismatches++;
          if (mismatches <= MAX_MISMATCH_SHOWN)
            $display({"mismatch exp idx=%0d res=%0d z=%0d f=%0b st=%0d l=%0b",
                      " / act idx=%0d res=%0d z=%0d f=%0b st=%0d l=%0b"},
                     e.idx, e.res, e.z, e.flag, e.status, e.last, obs_index_o, residual_o,
                     std_residual_o, outlier_flag_o, status_o, last_result_o);
        end
      end
    end
  end

  // receiver stall
  always @(posedge clk_i) begin
    if (hold_rx) out_stall_i <= 1'b1;
    else if (no_idle) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(99) < idle_pct);
  end

  // valid stays high after a pair so the next one can follow back to back
  task automatic send_pair(input logic signed [IN_W-1:0] a, input logic signed [IN_W-1:0] p,
                           input logic lst);
    while (!no_idle && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    actual_value_i <= a;
    predicted_value_i <= p;
    last_of_set_i <= lst;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_pair(a, p, lst);
  endtask

  // drop valid and wait for the next clock edge
  task automatic quiet_input();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    quiet_input();
    while (expected_words.size() != 0) @(posedge clk_i);
    // the block may still be finishing a set that produced nothing
    while (guard < 300) begin
      @(posedge clk_i);
      guard++;
    end
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    thr_q = v;
  endtask

  function automatic logic signed [IN_W-1:0] rnd_val(input int mode);
    case (mode)
      0: return $signed($urandom());
      1: return $signed(IN_W'($urandom_range(4000)) - 2000);
      default: return $signed(IN_W'($urandom_range(2000000)) - 1000000);
    endcase
  endfunction

  task automatic random_set(input int n, input bit lst_at_end);
    int mode;
    mode = $urandom_range(2);
    for (int i = 0; i < n; i++)
      send_pair(rnd_val(mode), rnd_val(mode), lst_at_end && (i == n - 1));
  endtask

  stim_row_t rows[$];

  initial begin
    int sent, n;
    stim_row_t r;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: short sets, extremes, flat set, an outlier set
    rows = '{
      '{32'sd5, 32'sd1, 1'b1, 1'b1, STATUS_FEW},
      '{32'sh7FFFFFFF, 32'sh80000000, 1'b0, 1'b0, STATUS_OK},
      '{32'sh80000000, 32'sh7FFFFFFF, 1'b1, 1'b1, STATUS_FEW},
      '{32'sh7FFFFFFF, 32'sh80000000, 1'b0, 1'b0, STATUS_OK},
      '{32'sh80000000, 32'sh7FFFFFFF, 1'b0, 1'b0, STATUS_OK},
      '{32'sh7FFFFFFF, 32'sh80000000, 1'b1, 1'b0, STATUS_OK},
      '{32'sd100, 32'sd0, 1'b0, 1'b0, STATUS_OK},
      '{32'sd100, 32'sd0, 1'b0, 1'b0, STATUS_OK},
      '{32'sd100, 32'sd0, 1'b0, 1'b0, STATUS_OK},
      '{32'sd100, 32'sd0, 1'b1, 1'b0, STATUS_OK},
      '{32'sd0, 32'sd0, 1'b0, 1'b0, STATUS_OK},
      '{32'sd65536, 32'sd0, 1'b0, 1'b0, STATUS_OK},
      '{-32'sd65536, 32'sd0, 1'b0, 1'b0, STATUS_OK},
      '{32'sd0, 32'sd1, 1'b0, 1'b0, STATUS_OK},
      '{32'sd0, 32'sd0, 1'b0, 1'b0, STATUS_OK},
      '{32'sd40000000, 32'sd0, 1'b1, 1'b0, STATUS_OK},
      '{32'sd1, 32'sd0, 1'b0, 1'b0, STATUS_OK},
      '{32'sd2, 32'sd0, 1'b0, 1'b0, STATUS_OK},
      '{32'sd4, 32'sd0, 1'b1, 1'b0, STATUS_OK}
    };
    foreach (rows[i]) begin
      r = rows[i];
      send_pair(r.act, r.pred, r.last);
      if (r.typed && expected_words.size() != 0 &&
          expected_words[$].status !== r.want_status) begin
        mismatches++;
        if (mismatches <= MAX_MISMATCH_SHOWN)
          $display("directed row %0d: exp status %0d act %0d", i, r.want_status,
                   expected_words[$].status);
      end
    end
    drain();

    // threshold extremes, then the capacity limit
    write_threshold('0);
    random_set(8, 1);
    drain();
    write_threshold(24'hFFFFFF);
    random_set(5, 1);
    drain();
    write_threshold(24'h010000);
    for (int i = 0; i < CAP; i++) send_pair(rnd_val(2), rnd_val(2), i == CAP - 1);
    drain();
    for (int i = 0; i < CAP + 2; i++) send_pair(rnd_val(1), rnd_val(1), i == CAP + 1);
    drain();
    write_threshold(THRESHOLD_RST);

    // pressure: receiver holds off long while sets keep coming
    hold_rx = 1;
    fork
      begin
        random_set(4, 1);
        random_set(4, 1);
      end
      begin
        repeat (2000) @(posedge clk_i);
        hold_rx = 0;
      end
    join
    drain();

    // random sets, mostly well formed
    sent = 0;
    while (sent < 50) begin
      if (sent >= 10 && sent < 35) no_idle = 1;
      else no_idle = 0;
      n = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 10);
      random_set(n, 1);
      sent += n;
      if ($urandom_range(7) == 0) begin
        quiet_input();
        while (expected_words.size() != 0) @(posedge clk_i);
      end
      if ($urandom_range(15) == 0) begin
        drain();
        write_threshold(THR_W'($urandom()));
      end
    end
    no_idle = 0;
    drain();

    if (mismatches == 0 && expected_words.size() == 0)
      $display("residual_zscore_outlier_flagger_top regression: pass");
    else
      $display("residual_zscore_outlier_flagger_top regression: fail");
    $finish;
  end

  initial begin
    #5ms;
    $display("residual_zscore_outlier_flagger_top regression: fail");
    $finish;
  end

endmodule
